@@ src/bqf_pkg.sv @@
// Shared constants and types for the Q2.14 biquad filter.
package bqf_pkg;

   localparam int COEF_BITS       = 16;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_INDEX_BITS  = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_A2 = 3'd4;

   localparam logic signed [COEF_BITS-1:0] COEF_UNITY = 16'sd16384;
   localparam logic signed [COEF_BITS-1:0] COEF_ZERO  = 16'sd0;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] b0;
      logic signed [COEF_BITS-1:0] b1;
      logic signed [COEF_BITS-1:0] b2;
      logic signed [COEF_BITS-1:0] a1;
      logic signed [COEF_BITS-1:0] a2;
   } coef_set_type;

endpackage

@@ src/biquad_filter_q2_14.sv @@
// Top level of the direct form I biquad filter with Q2.14 coefficients.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  req     | in        | req_valid / req_ready | req_sample_in  (signed samples)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_sample_out (signed samples)
//  csr     | in        | csr_we                | csr_index, csr_wdata (coefs)
//
// One transaction per cycle unless rsp is stalled; rsp_valid is registered after the queue.
// The feed-forward multiplies run in the front end; the feedback multiplies, rounding and
// saturation run combinationally before the back-end output register (output recursion).
// A two-entry queue lets the input side keep accepting while the output is stalled.
// Reset is synchronous and clears history, queue and coefficients (b0 = 1.0).
module biquad_filter_q2_14 #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   input  logic                                   csr_we,
   input  logic [bqf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic signed [bqf_pkg::COEF_BITS-1:0]   csr_wdata
);
   import bqf_pkg::*;

   localparam int FF_W = SAMPLE_BITS + COEF_BITS + 2;

   coef_set_type           coef_ff, coef_in;
   logic                   push_valid;
   logic signed [FF_W-1:0] push_data;
   logic                   queue_full;
   logic                   head_valid;
   logic [FF_W-1:0]        head_data;
   logic                   pop;

   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_B0:  coef_in.b0 = csr_wdata;
            CSR_B1:  coef_in.b1 = csr_wdata;
            CSR_B2:  coef_in.b2 = csr_wdata;
            CSR_A1:  coef_in.a1 = csr_wdata;
            CSR_A2:  coef_in.a2 = csr_wdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= COEF_UNITY;
         coef_ff.b1 <= COEF_ZERO;
         coef_ff.b2 <= COEF_ZERO;
         coef_ff.a1 <= COEF_ZERO;
         coef_ff.a2 <= COEF_ZERO;
      end else begin
         coef_ff <= coef_in;
      end
   end

   bqf_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .coef          (coef_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   bqf_queue #(
      .WIDTH (FF_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   bqf_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .coef           (coef_ff),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

@@ src/bqf_front.sv @@
// Front end: accepts input transactions, keeps input history, forms the feed-forward sum.
module bqf_front #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  bqf_pkg::coef_set_type                        coef,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic signed [SAMPLE_BITS-1:0]                req_sample_in,
   output logic                                         push_valid,
   output logic signed [SAMPLE_BITS+bqf_pkg::COEF_BITS+1:0] push_data,
   input  logic                                         queue_full
);
   import bqf_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int FF_W   = PROD_W + 2;

   logic signed [SAMPLE_BITS-1:0] prev_in_1_ff, prev_in_1_in;
   logic signed [SAMPLE_BITS-1:0] prev_in_2_ff, prev_in_2_in;
   logic signed [PROD_W-1:0]      x0_ext, x1_ext, x2_ext;
   logic signed [PROD_W-1:0]      c0_ext, c1_ext, c2_ext;
   logic signed [PROD_W-1:0]      p0, p1, p2;
   logic                          accept;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   assign x0_ext = PROD_W'(req_sample_in);
   assign x1_ext = PROD_W'(prev_in_1_ff);
   assign x2_ext = PROD_W'(prev_in_2_ff);
   assign c0_ext = PROD_W'(coef.b0);
   assign c1_ext = PROD_W'(coef.b1);
   assign c2_ext = PROD_W'(coef.b2);

   assign p0 = c0_ext * x0_ext;
   assign p1 = c1_ext * x1_ext;
   assign p2 = c2_ext * x2_ext;

   assign push_data = FF_W'(p0) + FF_W'(p1) + FF_W'(p2);

   always_comb begin
      prev_in_1_in = prev_in_1_ff;
      prev_in_2_in = prev_in_2_ff;
      if (accept) begin
         prev_in_1_in = req_sample_in;
         prev_in_2_in = prev_in_1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_in_1_ff <= '0;
         prev_in_2_ff <= '0;
      end else begin
         prev_in_1_ff <= prev_in_1_in;
         prev_in_2_ff <= prev_in_2_in;
      end
   end

endmodule

@@ src/bqf_queue.sv @@
// Short FIFO between front end and back end.
module bqf_queue #(
   parameter int WIDTH = 34,
   parameter int DEPTH = bqf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   import bqf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) !(pop && !head_valid))
      else $error("queue underflow");

endmodule

@@ src/bqf_back.sv @@
// Back end: feedback terms, rounding, saturation, output register and output history.
module bqf_back #(
   parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  bqf_pkg::coef_set_type                        coef,
   input  logic                                         head_valid,
   input  logic signed [SAMPLE_BITS+bqf_pkg::COEF_BITS+1:0] head_data,
   output logic                                         pop,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]                rsp_sample_out
);
   import bqf_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int FF_W   = PROD_W + 2;
   localparam int ACC_W  = PROD_W + 3;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (COEF_FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

   logic signed [SAMPLE_BITS-1:0] prev_out_1_ff, prev_out_1_in;
   logic signed [SAMPLE_BITS-1:0] prev_out_2_ff, prev_out_2_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out_ff, rsp_sample_out_in;
   logic signed [PROD_W-1:0]      y1_ext, y2_ext, a1_ext, a2_ext;
   logic signed [PROD_W-1:0]      p3, p4;
   logic signed [ACC_W-1:0]       acc, shifted;
   logic signed [SAMPLE_BITS-1:0] y;
   logic signed [FF_W-1:0]        ff_sum;

   assign ff_sum = head_data;
   assign y1_ext = PROD_W'(prev_out_1_ff);
   assign y2_ext = PROD_W'(prev_out_2_ff);
   assign a1_ext = PROD_W'(coef.a1);
   assign a2_ext = PROD_W'(coef.a2);
   assign p3     = a1_ext * y1_ext;
   assign p4     = a2_ext * y2_ext;

   assign acc     = ACC_W'(ff_sum) - ACC_W'(p3) - ACC_W'(p4) + ROUND_HALF;
   assign shifted = acc >>> COEF_FRAC_BITS;

   always_comb begin
      if (shifted > SMAX) begin
         y = SMAX[SAMPLE_BITS-1:0];
      end else if (shifted < SMIN) begin
         y = SMIN[SAMPLE_BITS-1:0];
      end else begin
         y = shifted[SAMPLE_BITS-1:0];
      end
   end

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      prev_out_1_in     = prev_out_1_ff;
      prev_out_2_in     = prev_out_2_ff;
      rsp_sample_out_in = rsp_sample_out_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         prev_out_1_in     = y;
         prev_out_2_in     = prev_out_1_ff;
         rsp_sample_out_in = y;
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_out_1_ff <= '0;
         prev_out_2_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_out_1_ff <= prev_out_1_in;
         prev_out_2_ff <= prev_out_2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   assert property (@(posedge clock) disable iff (reset) pop |=> rsp_valid_ff)
      else $error("popped transaction not presented");
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (prev_out_1_ff == rsp_sample_out_ff))
      else $error("output history out of step with result");

endmodule
